FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker file lrp_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Antecedent in this cycle implies consequent (same-cycle sequence form).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared constants, types and codes of the logit repetition penalty core.
// ----------------------------------------------------------------------------
`default_nettype none

package lrp_pkg;

  localparam int HistDepth   = 64;
  localparam int TokenBits   = 16;
  localparam int GroupSize   = 8;
  localparam int NumGroups   = (HistDepth + GroupSize - 1) / GroupSize;
  localparam int PartBits    = $clog2(GroupSize + 1);
  localparam int CountBits   = $clog2(HistDepth + 1);
  localparam int QueueDepth  = 2;
  localparam int QPtrBits    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntBits    = $clog2(QueueDepth + 1);

  localparam int IdBits      = 16;
  localparam int LogitBits   = 32;
  localparam int WinBits     = 7;
  localparam int FactorBits  = 16;
  localparam int AlphaBits   = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  localparam int ProdBits    = LogitBits + FactorBits + 1;
  localparam int FracShift   = 12;
  localparam int ScaledBits  = ProdBits - FracShift;
  localparam int FreqBits    = CountBits + 1 + AlphaBits;
  localparam int TermBits    = FreqBits + 1;
  localparam int SubBits     = TermBits + 8;
  localparam int DiffBits    = ScaledBits + 1;

  localparam logic [FactorBits-1:0] PenOne    = 16'd4096;
  localparam logic [ProdBits-1:0]   RoundBias = ProdBits'(2048);
  localparam logic [LogitBits-1:0]  LogitMax  = 32'h7fff_ffff;
  localparam logic [LogitBits-1:0]  LogitMin  = 32'h8000_0000;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWindowLen   = 3'd0,
    CfgPenalty     = 3'd1,
    CfgPenaltyRcp  = 3'd2,
    CfgAlphaFreq   = 3'd3,
    CfgAlphaPres   = 3'd4
  } lrp_cfg_idx_e;

  typedef enum logic {
    KindPush = 1'b0,
    KindCand = 1'b1
  } lrp_kind_e;

  typedef struct packed {
    logic [WinBits-1:0]    window_len;
    logic [FactorBits-1:0] pen_factor;
    logic [FactorBits-1:0] pen_recip;
    logic [AlphaBits-1:0]  freq_coef;
    logic [AlphaBits-1:0]  pres_coef;
  } lrp_cfg_t;

  typedef struct packed {
    logic [IdBits-1:0]                   cand_id;
    logic [LogitBits-1:0]                logit;
    logic [NumGroups-1:0][PartBits-1:0]  parts;
  } lrp_entry_t;

endpackage

`default_nettype wire

FILE: src/logit_repetition_penalty_core.sv
// ----------------------------------------------------------------------------
// logit_repetition_penalty_core
// Repetition, frequency and presence penalty on candidate logits.
//
// Channel  Handshake              Payload
// input    start / busy           kind_i, token_id_i, logit_in_i
// result   done_o strobe          cand_id_o, logit_out_o, occurrences_o,
//                                 saturated_o
// config   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One item is taken per cycle. A push updates the history at its accept
// edge and gives no result. A candidate is compared in its accept cycle;
// its result is strobed on done_o after it passes the queue slot and the
// 4 back stages.
// Reset clears the history to token 0 and loads the register defaults.
// The back end drains the queue every cycle, so busy never rises.
// ----------------------------------------------------------------------------
`default_nettype none

module logit_repetition_penalty_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              kind_i,
  input  wire logic [lrp_pkg::IdBits-1:0]        token_id_i,
  input  wire logic [lrp_pkg::LogitBits-1:0]     logit_in_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lrp_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  wire logic [lrp_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  output logic                                   done_o,
  output logic [lrp_pkg::IdBits-1:0]             cand_id_o,
  output logic [lrp_pkg::LogitBits-1:0]          logit_out_o,
  output logic [lrp_pkg::CountBits-1:0]          occurrences_o,
  output logic                                   saturated_o
);

  lrp_pkg::lrp_cfg_t   cfg_q, cfg_d;
  lrp_pkg::lrp_entry_t front_entry, back_entry;
  logic                accept, q_push, q_empty, q_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lrp_pkg::lrp_cfg_idx_e'(cfg_idx_i))
        lrp_pkg::CfgWindowLen:  cfg_d.window_len = cfg_wdata_i[lrp_pkg::WinBits-1:0];
        lrp_pkg::CfgPenalty:    cfg_d.pen_factor = cfg_wdata_i;
        lrp_pkg::CfgPenaltyRcp: cfg_d.pen_recip = cfg_wdata_i;
        lrp_pkg::CfgAlphaFreq:  cfg_d.freq_coef = cfg_wdata_i;
        lrp_pkg::CfgAlphaPres:  cfg_d.pres_coef = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len <= lrp_pkg::WinBits'(lrp_pkg::HistDepth);
      cfg_q.pen_factor <= lrp_pkg::PenOne;
      cfg_q.pen_recip  <= lrp_pkg::PenOne;
      cfg_q.freq_coef  <= '0;
      cfg_q.pres_coef  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  lrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .token_id_i   (token_id_i),
    .logit_in_i   (logit_in_i),
    .window_len_i (cfg_q.window_len),
    .push_o       (q_push),
    .entry_o      (front_entry)
  );

  lrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .pop_i   (!q_empty),
    .entry_o (back_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lrp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_empty),
    .entry_i       (back_entry),
    .cfg_i         (cfg_q),
    .done_o        (done_o),
    .cand_id_o     (cand_id_o),
    .logit_out_o   (logit_out_o),
    .occurrences_o (occurrences_o),
    .saturated_o   (saturated_o)
  );

endmodule

`default_nettype wire

FILE: src/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front
// Token history shift line; classifies items, counts window matches per group.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic                           kind_i,
  input  wire logic [lrp_pkg::IdBits-1:0]     token_id_i,
  input  wire logic [lrp_pkg::LogitBits-1:0]  logit_in_i,
  input  wire logic [lrp_pkg::WinBits-1:0]    window_len_i,
  output logic                                push_o,
  output lrp_pkg::lrp_entry_t                 entry_o
);

  logic [lrp_pkg::TokenBits-1:0] hist_q [lrp_pkg::HistDepth];
  logic [lrp_pkg::TokenBits-1:0] key;
  logic                          is_cand;
  logic [lrp_pkg::NumGroups-1:0][lrp_pkg::PartBits-1:0] parts;

  assign key     = token_id_i[lrp_pkg::TokenBits-1:0];
  assign is_cand = (lrp_pkg::lrp_kind_e'(kind_i) == lrp_pkg::KindCand);

  // tap 0 holds the newest token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lrp_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else if (accept_i && !is_cand) begin
      hist_q[0] <= key;
      for (int i = 1; i < lrp_pkg::HistDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_comb begin
    int idx;
    idx = 0;
    for (int g = 0; g < lrp_pkg::NumGroups; g++) begin
      parts[g] = '0;
      for (int j = 0; j < lrp_pkg::GroupSize; j++) begin
        idx = g * lrp_pkg::GroupSize + j;
        if (idx < lrp_pkg::HistDepth) begin
          if (hist_q[idx] == key && idx < int'(window_len_i)) begin
            parts[g] = parts[g] + lrp_pkg::PartBits'(1);
          end
        end
      end
    end
  end

  assign push_o           = accept_i && is_cand;
  assign entry_o.cand_id  = token_id_i;
  assign entry_o.logit    = logit_in_i;
  assign entry_o.parts    = parts;

endmodule

`default_nettype wire

FILE: src/lrp_queue.sv
// ----------------------------------------------------------------------------
// lrp_queue
// Short FIFO of classified candidates between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  lrp_pkg::lrp_entry_t entry_i,
  input  wire logic           pop_i,
  output lrp_pkg::lrp_entry_t entry_o,
  output logic                empty_o,
  output logic                full_o
);

  lrp_pkg::lrp_entry_t              mem_q [lrp_pkg::QueueDepth];
  logic [lrp_pkg::QPtrBits-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [lrp_pkg::QCntBits-1:0]     cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == lrp_pkg::QCntBits'(lrp_pkg::QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == lrp_pkg::QPtrBits'(lrp_pkg::QueueDepth - 1)) ? '0
           : wr_q + lrp_pkg::QPtrBits'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == lrp_pkg::QPtrBits'(lrp_pkg::QueueDepth - 1)) ? '0
           : rd_q + lrp_pkg::QPtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + lrp_pkg::QCntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - lrp_pkg::QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back
// Penalty datapath: count sum, multiply, round, subtract, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  lrp_pkg::lrp_entry_t                  entry_i,
  input  lrp_pkg::lrp_cfg_t                    cfg_i,
  output logic                                 done_o,
  output logic [lrp_pkg::IdBits-1:0]           cand_id_o,
  output logic [lrp_pkg::LogitBits-1:0]        logit_out_o,
  output logic [lrp_pkg::CountBits-1:0]        occurrences_o,
  output logic                                 saturated_o
);

  // stage 1: occurrence count
  logic                                v1_q;
  logic [lrp_pkg::IdBits-1:0]          id1_q;
  logic signed [lrp_pkg::LogitBits-1:0] x1_q;
  logic [lrp_pkg::CountBits-1:0]       cnt1_q, cnt1_d;

  // stage 2: products
  logic                                v2_q, pen2_q, has2_q;
  logic [lrp_pkg::IdBits-1:0]          id2_q;
  logic signed [lrp_pkg::LogitBits-1:0] x2_q;
  logic [lrp_pkg::CountBits-1:0]       cnt2_q;
  logic signed [lrp_pkg::ProdBits-1:0] prod2_q, prod2_d;
  logic signed [lrp_pkg::FreqBits-1:0] freq2_q, freq2_d;
  logic [lrp_pkg::FactorBits-1:0]      factor;

  // stage 3: scaled logit and subtrahend
  logic                                  v3_q;
  logic [lrp_pkg::IdBits-1:0]            id3_q;
  logic [lrp_pkg::CountBits-1:0]         cnt3_q;
  logic signed [lrp_pkg::ScaledBits-1:0] xs3_q, xs3_d;
  logic signed [lrp_pkg::SubBits-1:0]    sub3_q, sub3_d;
  logic signed [lrp_pkg::ProdBits-1:0]   prod_rnd;
  logic signed [lrp_pkg::TermBits-1:0]   term;

  // stage 4: output
  logic                                  v4_q;
  logic [lrp_pkg::IdBits-1:0]            id4_q;
  logic [lrp_pkg::CountBits-1:0]         cnt4_q;
  logic [lrp_pkg::LogitBits-1:0]         out4_q, out4_d;
  logic                                  sat4_q, sat4_d;
  logic signed [lrp_pkg::DiffBits-1:0]   diff;
  logic [lrp_pkg::DiffBits-lrp_pkg::LogitBits:0] top_bits;

  always_comb begin
    cnt1_d = '0;
    for (int g = 0; g < lrp_pkg::NumGroups; g++) begin
      cnt1_d = cnt1_d + lrp_pkg::CountBits'(entry_i.parts[g]);
    end
  end

  always_comb begin
    factor  = (x1_q <= 0) ? cfg_i.pen_factor : cfg_i.pen_recip;
    prod2_d = lrp_pkg::ProdBits'(x1_q)
            * lrp_pkg::ProdBits'($signed({1'b0, factor}));
    freq2_d = lrp_pkg::FreqBits'($signed({1'b0, cnt1_q}))
            * lrp_pkg::FreqBits'($signed(cfg_i.freq_coef));
  end

  always_comb begin
    prod_rnd = prod2_q + $signed(lrp_pkg::RoundBias);
    xs3_d    = pen2_q ? prod_rnd[lrp_pkg::ProdBits-1:lrp_pkg::FracShift]
                      : lrp_pkg::ScaledBits'(x2_q);
    term     = lrp_pkg::TermBits'(freq2_q)
             + lrp_pkg::TermBits'($signed(cfg_i.pres_coef));
    sub3_d   = has2_q ? $signed({term, 8'b0}) : '0;
  end

  always_comb begin
    diff     = lrp_pkg::DiffBits'(xs3_q) - lrp_pkg::DiffBits'(sub3_q);
    top_bits = diff[lrp_pkg::DiffBits-1:lrp_pkg::LogitBits-1];
    sat4_d   = !((top_bits == '0) || (top_bits == '1));
    if (sat4_d) begin
      out4_d = diff[lrp_pkg::DiffBits-1] ? lrp_pkg::LogitMin : lrp_pkg::LogitMax;
    end else begin
      out4_d = diff[lrp_pkg::LogitBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    id1_q   <= entry_i.cand_id;
    x1_q    <= $signed(entry_i.logit);
    cnt1_q  <= cnt1_d;

    id2_q   <= id1_q;
    x2_q    <= x1_q;
    cnt2_q  <= cnt1_q;
    has2_q  <= (cnt1_q != '0);
    pen2_q  <= (cnt1_q != '0) && (cfg_i.pen_factor != lrp_pkg::PenOne);
    prod2_q <= prod2_d;
    freq2_q <= freq2_d;

    id3_q   <= id2_q;
    cnt3_q  <= cnt2_q;
    xs3_q   <= xs3_d;
    sub3_q  <= sub3_d;

    id4_q   <= id3_q;
    cnt4_q  <= cnt3_q;
    out4_q  <= out4_d;
    sat4_q  <= sat4_d;
  end

  assign done_o        = v4_q;
  assign cand_id_o     = id4_q;
  assign logit_out_o   = out4_q;
  assign occurrences_o = cnt4_q;
  assign saturated_o   = sat4_q;

endmodule

`default_nettype wire

FILE: src/lrp_checker.sv
// ----------------------------------------------------------------------------
// lrp_checker
// Port-level checks of the penalty core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrp_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic                              kind_i,
  input  wire logic [lrp_pkg::IdBits-1:0]        token_id_i,
  input  wire logic [lrp_pkg::LogitBits-1:0]     logit_in_i,
  input  wire logic                              done_o,
  input  wire logic [lrp_pkg::IdBits-1:0]        cand_id_o,
  input  wire logic [lrp_pkg::LogitBits-1:0]     logit_out_o,
  input  wire logic [lrp_pkg::CountBits-1:0]     occurrences_o,
  input  wire logic                              saturated_o
);

  logic cand_acc;
  logic no_hit;

  assign cand_acc = rst_ni && start && !busy && kind_i;
  assign no_hit   = done_o && (occurrences_o == '0);

  // an accepted candidate's result appears on done_o with its id
  `ASSERT_IMPLIES(a_cand_result, clk_i, rst_ni, cand_acc, ##5 (done_o && cand_id_o == $past(token_id_i, 5)))

  // no result without an earlier accepted candidate
  `ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, done_o, $past(cand_acc, 5))

  // without a match the logit passes untouched
  `ASSERT_IMPLIES(a_passthrough, clk_i, rst_ni, no_hit, !saturated_o && logit_out_o == $past(logit_in_i, 5))

  // count never exceeds the history depth
  `ASSERT_IMPLIES(a_count_range, clk_i, rst_ni, done_o, occurrences_o <= lrp_pkg::CountBits'(lrp_pkg::HistDepth))

endmodule

bind logit_repetition_penalty_core lrp_checker u_lrp_checker (.*);

`default_nettype wire
